[src/vlrp_pkg.sv]
`timescale 1ns / 1ps

package vlrp_pkg;

    // item kinds on the input channel
    typedef enum logic [1:0] {
        FUNC_QUERY_MARK   = 2'd0,
        FUNC_FRAME_ENC    = 2'd1,
        FUNC_REF_LOST     = 2'd2,
        FUNC_RESET_STATE  = 2'd3
    } func_t;

    // recovery actions on the result channel
    typedef enum logic [1:0] {
        ACT_NONE       = 2'd0,
        ACT_KEYFRAME   = 2'd1,
        ACT_INVALIDATE = 2'd2,
        ACT_REFRESH    = 2'd3
    } action_t;

    // configuration register indexes
    localparam logic REG_LONG_TERM_CAPABLE = 1'b0;
    localparam logic REG_REFRESH_CAPABLE   = 1'b1;

    // policy constants
    localparam int unsigned LONG_TERM_INTERVAL = 30;
    localparam int unsigned REFRESH_FRAMES     = 16;
    localparam int unsigned REFRESH_MAX        = 31;

    // count of trailing zero bits of a divisor in 1..1024
    function automatic int unsigned trailing_zeros(input int unsigned v);
        int unsigned n;
        logic        hit;
        n   = 0;
        hit = 1'b0;
        for (int i = 0; i < 11; i++) begin
            if (!hit && v[i] == 1'b0) begin
                n = n + 1;
            end else begin
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    // multiplicative inverse of an odd number mod 2^32 (newton steps)
    function automatic logic [31:0] odd_inverse(input logic [31:0] d);
        logic [31:0] inv;
        inv = d;
        for (int i = 0; i < 5; i++) begin
            inv = inv * (32'd2 - d * inv);
        end
        return inv;
    endfunction

    // divisibility test by LONG_TERM_INTERVAL = 2^LT_SHIFT * LT_ODD:
    // low LT_SHIFT bits zero and (x >> LT_SHIFT) * inv(LT_ODD) within limit
    localparam int unsigned LT_SHIFT = trailing_zeros(LONG_TERM_INTERVAL);
    localparam int unsigned LT_ODD   = LONG_TERM_INTERVAL >> LT_SHIFT;
    localparam int unsigned LT_BITS  = 32 - LT_SHIFT;
    localparam logic [31:0] LT_INV   = odd_inverse(LT_ODD[31:0]);
    localparam logic [63:0] LT_SPAN  = (64'd1 << LT_BITS) - 64'd1;
    localparam logic [63:0] LT_LIMIT = LT_SPAN / LT_ODD;
    localparam logic [31:0] LT_MASK  = LT_SPAN[31:0];
    localparam logic [31:0] LT_LOW   = 32'((64'd1 << LT_SHIFT) - 64'd1);

    // countdown load, saturated to the 5-bit counter
    localparam logic [4:0] REFRESH_LOAD =
        (REFRESH_FRAMES > REFRESH_MAX) ? 5'(REFRESH_MAX) : 5'(REFRESH_FRAMES);

endpackage

[src/video_loss_recovery_policy_top.sv]
`timescale 1ns / 1ps

// channel  | direction | handshake          | word
// ---------+-----------+--------------------+------------------------------------------
// s_       | in        | s_valid / s_ready  | func, frame_id, is_idr, was_marked
// m_       | out       | m_valid / m_ready  | action, reference_frame_id, mark_long_term,
//          |           |                    | refresh_active, long_term_valid,
//          |           |                    | newest_long_term_id
// apb      | in        | psel/penable/pready| capability registers at 0x0 and 0x4
//
// one word per cycle while s_ready is high; result valid the cycle after acceptance
// the policy state updates in the same cycle a word is accepted, so words can
// follow back to back
// s_ready is high whenever the result register is empty or being drained
// aresetn (synchronous, active low) clears the state and both capability bits
// a write to either capability register also clears the policy state

module video_loss_recovery_policy_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [31:0] s_frame_id,
    input  logic        s_is_idr,
    input  logic        s_was_marked,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_action,
    output logic [31:0] m_reference_frame_id,
    output logic        m_mark_long_term,
    output logic        m_refresh_active,
    output logic        m_long_term_valid,
    output logic [31:0] m_newest_long_term_id,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // capability registers
    logic long_term_capable_reg;
    logic refresh_capable_reg;

    // policy state
    logic [31:0] newest_long_term_reg, newest_long_term_next;
    logic        long_term_held_reg, long_term_held_next;
    logic [4:0]  refresh_left_reg, refresh_left_next;
    logic        recovery_pending_reg, recovery_pending_next;

    // result register
    logic                    m_valid_reg;
    vlrp_pkg::action_t       m_action_reg, m_action_next;
    logic [31:0]             m_reference_frame_id_reg, m_reference_frame_id_next;
    logic                    m_mark_long_term_reg, m_mark_long_term_next;
    logic                    m_refresh_active_reg;
    logic                    m_long_term_valid_reg;
    logic [31:0]             m_newest_long_term_id_reg;

    logic        s_accept;
    logic        cfg_write;
    logic [31:0] lt_quot;
    logic [31:0] lt_prod;
    logic        lt_divisible;
    logic        lt_update;
    vlrp_pkg::func_t func;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign func      = vlrp_pkg::func_t'(s_func);

    // register readback
    always_comb begin
        prdata = 32'd0;
        case (paddr[2])
            vlrp_pkg::REG_LONG_TERM_CAPABLE: prdata = {31'd0, long_term_capable_reg};
            vlrp_pkg::REG_REFRESH_CAPABLE:   prdata = {31'd0, refresh_capable_reg};
            default:                         prdata = 32'd0;
        endcase
    end

    // frame id divisibility by the long-term interval via odd inverse multiply
    assign lt_quot      = s_frame_id >> vlrp_pkg::LT_SHIFT;
    assign lt_prod      = (lt_quot * vlrp_pkg::LT_INV) & vlrp_pkg::LT_MASK;
    assign lt_divisible = ((s_frame_id & vlrp_pkg::LT_LOW) == 32'd0)
                          && ({32'd0, lt_prod} <= vlrp_pkg::LT_LIMIT);

    // encoded IDR or marked frame becomes the newest long-term reference when capable and newer
    assign lt_update = long_term_capable_reg && (s_is_idr || s_was_marked)
                       && !(long_term_held_reg && (s_frame_id <= newest_long_term_reg));

    // policy decision
    always_comb begin
        newest_long_term_next     = newest_long_term_reg;
        long_term_held_next       = long_term_held_reg;
        refresh_left_next         = refresh_left_reg;
        recovery_pending_next     = recovery_pending_reg;
        m_action_next             = vlrp_pkg::ACT_NONE;
        m_reference_frame_id_next = 32'd0;
        m_mark_long_term_next     = 1'b0;
        case (func)
            vlrp_pkg::FUNC_QUERY_MARK: begin
                m_mark_long_term_next = long_term_capable_reg && lt_divisible;
            end
            vlrp_pkg::FUNC_FRAME_ENC: begin
                if (refresh_left_reg != 5'd0) begin
                    refresh_left_next = refresh_left_reg - 5'd1;
                end
                recovery_pending_next = 1'b0;
                if (lt_update) begin
                    newest_long_term_next = s_frame_id;
                    long_term_held_next   = 1'b1;
                end
            end
            vlrp_pkg::FUNC_REF_LOST: begin
                if (refresh_left_reg != 5'd0 && !recovery_pending_reg) begin
                    m_action_next = vlrp_pkg::ACT_NONE;
                end else if (long_term_capable_reg && long_term_held_reg
                             && (newest_long_term_reg < s_frame_id)
                             && !recovery_pending_reg) begin
                    m_action_next             = vlrp_pkg::ACT_INVALIDATE;
                    m_reference_frame_id_next = newest_long_term_reg;
                    recovery_pending_next     = 1'b1;
                end else if (refresh_capable_reg && refresh_left_reg == 5'd0
                             && !recovery_pending_reg) begin
                    m_action_next         = vlrp_pkg::ACT_REFRESH;
                    refresh_left_next     = vlrp_pkg::REFRESH_LOAD;
                    recovery_pending_next = 1'b1;
                end else begin
                    m_action_next         = vlrp_pkg::ACT_KEYFRAME;
                    long_term_held_next   = 1'b0;
                    refresh_left_next     = 5'd0;
                    recovery_pending_next = 1'b1;
                end
            end
            vlrp_pkg::FUNC_RESET_STATE: begin
                newest_long_term_next = 32'd0;
                long_term_held_next   = 1'b0;
                refresh_left_next     = 5'd0;
                recovery_pending_next = 1'b0;
            end
            default: begin
                m_action_next = vlrp_pkg::ACT_NONE;
            end
        endcase
    end

    // capability registers and policy state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_term_capable_reg <= 1'b0;
            refresh_capable_reg   <= 1'b0;
            newest_long_term_reg  <= 32'd0;
            long_term_held_reg    <= 1'b0;
            refresh_left_reg      <= 5'd0;
            recovery_pending_reg  <= 1'b0;
        end else if (cfg_write) begin
            case (paddr[2])
                vlrp_pkg::REG_LONG_TERM_CAPABLE: long_term_capable_reg <= pwdata[0];
                vlrp_pkg::REG_REFRESH_CAPABLE:   refresh_capable_reg   <= pwdata[0];
                default:                         long_term_capable_reg <= long_term_capable_reg;
            endcase
            newest_long_term_reg <= 32'd0;
            long_term_held_reg   <= 1'b0;
            refresh_left_reg     <= 5'd0;
            recovery_pending_reg <= 1'b0;
        end else if (s_accept) begin
            newest_long_term_reg <= newest_long_term_next;
            long_term_held_reg   <= long_term_held_next;
            refresh_left_reg     <= refresh_left_next;
            recovery_pending_reg <= recovery_pending_next;
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_action_reg                 <= m_action_next;
            m_reference_frame_id_reg     <= m_reference_frame_id_next;
            m_mark_long_term_reg         <= m_mark_long_term_next;
            m_refresh_active_reg         <= (refresh_left_next != 5'd0);
            m_long_term_valid_reg        <= long_term_held_next;
            m_newest_long_term_id_reg    <= newest_long_term_next;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_action              = m_action_reg;
    assign m_reference_frame_id  = m_reference_frame_id_reg;
    assign m_mark_long_term      = m_mark_long_term_reg;
    assign m_refresh_active      = m_refresh_active_reg;
    assign m_long_term_valid     = m_long_term_valid_reg;
    assign m_newest_long_term_id = m_newest_long_term_id_reg;

    // countdown never exceeds its load value
    a_refresh_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        refresh_left_reg <= vlrp_pkg::REFRESH_LOAD)
        else $error("refresh countdown above load value");

    // an accepted word always leaves a result behind
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid_reg)
        else $error("accepted word produced no result");

    // invalidate only falls back to a held long-term reference
    a_invalidate_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_action_reg == vlrp_pkg::ACT_INVALIDATE) |-> m_long_term_valid_reg)
        else $error("invalidate without held long-term reference");

    // a keyframe drops the long-term reference and stops refresh
    a_keyframe_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_action_reg == vlrp_pkg::ACT_KEYFRAME)
        |-> (!m_long_term_valid_reg && !m_refresh_active_reg))
        else $error("keyframe left long-term or refresh state");

    // a mark answer never comes with a recovery action
    a_mark_no_action: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_mark_long_term_reg) |-> (m_action_reg == vlrp_pkg::ACT_NONE))
        else $error("mark answer carries an action");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import vlrp_pkg::*;

    // one input word
    typedef struct packed {
        func_t       func;
        logic [31:0] frame_id;
        logic        is_idr;
        logic        was_marked;
    } frame_event_t;

    // one result word
    typedef struct packed {
        action_t     action;
        logic [31:0] reference_frame_id;
        logic        mark_long_term;
        logic        refresh_active;
        logic        long_term_valid;
        logic [31:0] newest_long_term_id;
    } recovery_decision_t;

    localparam int          PHASE_ITEMS = 204;
    localparam int          LONG_HOLD   = 300;
    localparam logic [7:0]  LT_PLAN     = 8'b1011_0101;
    localparam logic [7:0]  RF_PLAN     = 8'b0111_1001;
    localparam logic [4:0]  REFRESH_RELOAD =
        (REFRESH_FRAMES > REFRESH_MAX) ? 5'(REFRESH_MAX) : 5'(REFRESH_FRAMES);

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func       = 2'd0;
    logic [31:0] s_frame_id   = 32'd0;
    logic        s_is_idr     = 1'b0;
    logic        s_was_marked = 1'b0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [1:0]  m_action;
    logic [31:0] m_reference_frame_id;
    logic        m_mark_long_term;
    logic        m_refresh_active;
    logic        m_long_term_valid;
    logic [31:0] m_newest_long_term_id;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = 3'd0;
    logic [31:0] pwdata       = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // predicted policy state and capability bits
    logic        lt_capable;
    logic        rf_capable;
    logic [31:0] lt_newest;
    logic        lt_held;
    logic [4:0]  refresh_left;
    logic        recovery_pending;

    frame_event_t       events_to_send[$];
    recovery_decision_t decisions_due[$];
    frame_event_t       offered;
    int                 mismatches     = 0;
    bit                 gaps_enabled   = 1'b1;
    bit                 long_stall_req = 1'b0;
    int                 burst_left     = 0;
    int                 gap_left       = 0;
    int                 hold_left      = 0;
    int                 pattern_left   = 0;
    int                 stall_mode     = 0;

    video_loss_recovery_policy_top DUT (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_func                (s_func),
        .s_frame_id            (s_frame_id),
        .s_is_idr              (s_is_idr),
        .s_was_marked          (s_was_marked),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_action              (m_action),
        .m_reference_frame_id  (m_reference_frame_id),
        .m_mark_long_term      (m_mark_long_term),
        .m_refresh_active      (m_refresh_active),
        .m_long_term_valid     (m_long_term_valid),
        .m_newest_long_term_id (m_newest_long_term_id),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready)
    );

    always #2 aclk = ~aclk;

    function automatic void clear_policy();
        lt_newest        = 32'd0;
        lt_held          = 1'b0;
        refresh_left     = 5'd0;
        recovery_pending = 1'b0;
    endfunction

    // recovery decision for one frame event, updates the predicted state
    function automatic recovery_decision_t decide_recovery(input frame_event_t ev);
        recovery_decision_t d;
        d = '0;
        case (ev.func)
            FUNC_QUERY_MARK: begin
                d.mark_long_term = lt_capable && (ev.frame_id % LONG_TERM_INTERVAL == 0);
            end
            FUNC_FRAME_ENC: begin
                if (refresh_left != 0) begin
                    refresh_left = refresh_left - 5'd1;
                end
                recovery_pending = 1'b0;
                if (lt_capable && (ev.is_idr || ev.was_marked) &&
                    !(lt_held && ev.frame_id <= lt_newest)) begin
                    lt_newest = ev.frame_id;
                    lt_held   = 1'b1;
                end
            end
            FUNC_REF_LOST: begin
                if (refresh_left != 0 && !recovery_pending) begin
                    d.action = ACT_NONE;
                end else if (lt_capable && lt_held && lt_newest < ev.frame_id &&
                             !recovery_pending) begin
                    d.action             = ACT_INVALIDATE;
                    d.reference_frame_id = lt_newest;
                    recovery_pending     = 1'b1;
                end else if (rf_capable && refresh_left == 0 && !recovery_pending) begin
                    d.action         = ACT_REFRESH;
                    refresh_left     = REFRESH_RELOAD;
                    recovery_pending = 1'b1;
                end else begin
                    d.action         = ACT_KEYFRAME;
                    lt_held          = 1'b0;
                    refresh_left     = 5'd0;
                    recovery_pending = 1'b1;
                end
            end
            default: begin
                clear_policy();
            end
        endcase
        d.refresh_active      = (refresh_left != 0);
        d.long_term_valid     = lt_held;
        d.newest_long_term_id = lt_newest;
        return d;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            mismatches++;
        end
    endfunction

    // mostly a plausible encoder stream, with some noise
    function automatic frame_event_t random_event(inout logic [31:0] frame_no);
        frame_event_t ev;
        int unsigned  pick;
        ev.is_idr     = 1'($urandom_range(0, 1));
        ev.was_marked = 1'($urandom_range(0, 1));
        pick          = $urandom_range(0, 99);
        if (pick < 45) begin
            frame_no      = frame_no + 32'd1;
            ev.func       = FUNC_FRAME_ENC;
            ev.frame_id   = frame_no;
            ev.is_idr     = ($urandom_range(0, 19) == 0);
            ev.was_marked = (frame_no % LONG_TERM_INTERVAL == 0) || ($urandom_range(0, 9) == 0);
        end else if (pick < 63) begin
            ev.func     = FUNC_QUERY_MARK;
            ev.frame_id = frame_no + 32'd1;
        end else if (pick < 88) begin
            ev.func     = FUNC_REF_LOST;
            ev.frame_id = frame_no - 32'($urandom_range(0, 40));
        end else if (pick < 91) begin
            ev.func     = FUNC_RESET_STATE;
            ev.frame_id = $urandom();
        end else begin
            ev.func     = func_t'($urandom_range(0, 3));
            ev.frame_id = $urandom();
        end
        return ev;
    endfunction

    function automatic void push_event(input func_t f, input logic [31:0] id,
                                       input logic idr, input logic marked);
        frame_event_t ev;
        ev.func       = f;
        ev.frame_id   = id;
        ev.is_idr     = idr;
        ev.was_marked = marked;
        events_to_send.push_back(ev);
    endfunction

    // apb write: setup then access
    task automatic write_capability(input logic index, input logic value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {31'($urandom()), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_LONG_TERM_CAPABLE) begin
            lt_capable = value;
        end else begin
            rf_capable = value;
        end
        clear_policy();
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (events_to_send.size() != 0 || s_valid || decisions_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // input driver: bursts of words separated by random gaps while gaps are enabled
    always @(posedge aclk) begin
        logic offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            offer = s_valid;
            if (s_valid && s_ready) begin
                decisions_due.push_back(decide_recovery(offered));
                offer = 1'b0;
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (events_to_send.size() != 0) begin
                    offered = events_to_send.pop_front();
                    offer   = 1'b1;
                    s_func       <= offered.func;
                    s_frame_id   <= offered.frame_id;
                    s_is_idr     <= offered.is_idr;
                    s_was_marked <= offered.was_marked;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = gaps_enabled ? $urandom_range(1, 8) : 0;
                    end
                end
            end
            s_valid <= offer;
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge aclk) begin
        recovery_decision_t d;
        logic               take;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (decisions_due.size() == 0) begin
                    $error("result word with no expected decision");
                    mismatches++;
                end else begin
                    d = decisions_due.pop_front();
                    check_field("action", 32'(d.action), 32'(m_action));
                    check_field("reference_frame_id", d.reference_frame_id,
                                m_reference_frame_id);
                    check_field("mark_long_term", 32'(d.mark_long_term),
                                32'(m_mark_long_term));
                    check_field("refresh_active", 32'(d.refresh_active),
                                32'(m_refresh_active));
                    check_field("long_term_valid", 32'(d.long_term_valid),
                                32'(m_long_term_valid));
                    check_field("newest_long_term_id", d.newest_long_term_id,
                                m_newest_long_term_id);
                end
            end
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                hold_left      = LONG_HOLD;
            end
            if (pattern_left == 0) begin
                stall_mode   = $urandom_range(0, 3);
                pattern_left = $urandom_range(8, 80);
            end else begin
                pattern_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end else begin
                case (stall_mode)
                    0: take = 1'b1;
                    1: take = 1'($urandom_range(0, 1));
                    2: take = ($urandom_range(0, 3) == 0);
                    default: take = ~m_ready;
                endcase
            end
            m_ready <= take;
        end
    end

    // stimulus sequence
    initial begin
        logic [31:0] frame_no;
        lt_capable = 1'b0;
        rf_capable = 1'b0;
        clear_policy();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes and each recovery path
        write_capability(REG_LONG_TERM_CAPABLE, 1'b1);
        write_capability(REG_REFRESH_CAPABLE, 1'b1);
        push_event(FUNC_QUERY_MARK, 32'd0, 1'b0, 1'b0);
        push_event(FUNC_QUERY_MARK, 32'd30, 1'b0, 1'b0);
        push_event(FUNC_QUERY_MARK, 32'd29, 1'b0, 1'b0);
        push_event(FUNC_QUERY_MARK, 32'hFFFF_FFFF, 1'b1, 1'b1);
        push_event(FUNC_QUERY_MARK, 32'hFFFF_FFF0, 1'b0, 1'b0);
        // nothing held: refresh, then keyframe while pending
        push_event(FUNC_REF_LOST, 32'd5, 1'b0, 1'b0);
        push_event(FUNC_REF_LOST, 32'd6, 1'b0, 1'b0);
        // long-term tracking, older and equal ids ignored
        push_event(FUNC_FRAME_ENC, 32'd100, 1'b1, 1'b0);
        push_event(FUNC_FRAME_ENC, 32'd200, 1'b0, 1'b1);
        push_event(FUNC_FRAME_ENC, 32'd150, 1'b0, 1'b1);
        push_event(FUNC_FRAME_ENC, 32'd200, 1'b1, 1'b0);
        // invalidate, then keyframe while pending
        push_event(FUNC_REF_LOST, 32'd300, 1'b0, 1'b0);
        push_event(FUNC_REF_LOST, 32'd301, 1'b0, 1'b0);
        push_event(FUNC_FRAME_ENC, 32'd250, 1'b0, 1'b0);
        // refresh, then loss while refresh runs with nothing pending
        push_event(FUNC_REF_LOST, 32'd260, 1'b0, 1'b0);
        push_event(FUNC_FRAME_ENC, 32'd261, 1'b0, 1'b0);
        push_event(FUNC_REF_LOST, 32'd262, 1'b0, 1'b0);
        push_event(FUNC_REF_LOST, 32'd263, 1'b0, 1'b0);
        push_event(FUNC_FRAME_ENC, 32'd264, 1'b0, 1'b1);
        push_event(FUNC_REF_LOST, 32'd265, 1'b0, 1'b0);
        push_event(FUNC_RESET_STATE, 32'hFFFF_FFFF, 1'b1, 1'b1);
        push_event(FUNC_FRAME_ENC, 32'hFFFF_FFFF, 1'b1, 1'b1);
        push_event(FUNC_REF_LOST, 32'hFFFF_FFFF, 1'b1, 1'b1);
        push_event(FUNC_RESET_STATE, 32'd0, 1'b0, 1'b0);
        push_event(FUNC_QUERY_MARK, 32'd60, 1'b1, 1'b1);
        wait_idle();

        // random phases over the capability settings
        for (int p = 0; p < 8; p++) begin
            gaps_enabled = (p != 5);
            write_capability(REG_LONG_TERM_CAPABLE, LT_PLAN[p]);
            write_capability(REG_REFRESH_CAPABLE, RF_PLAN[p]);
            case (p % 3)
                0: frame_no = $urandom_range(0, 1000);
                1: frame_no = $urandom();
                default: frame_no = 32'hFFFF_FF00 + 32'($urandom_range(0, 200));
            endcase
            // receiver holds off while the sender keeps offering
            if (p == 5) begin
                long_stall_req = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                events_to_send.push_back(random_event(frame_no));
                // sender pause until everything has drained
                if (p == 3 && i == PHASE_ITEMS / 2) begin
                    wait_idle();
                end
            end
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0 && decisions_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[video_loss_recovery_policy_top.f]
src/vlrp_pkg.sv
src/video_loss_recovery_policy_top.sv
verif/tb.sv
